[design/asa_pkg.sv]
// Shared types, codes and sizing constants of the aligned stack allocator.
package asa_pkg;

  // Region and header sizing.
  localparam int REGION_BYTES   = 1024;
  localparam int HEADER_BYTES   = 12;
  localparam int MAX_ALIGN_LOG2 = 6;

  // Field widths.
  localparam int OFF_W   = 11;
  localparam int ADDR_W  = 32;
  localparam int ALOG_W  = 3;
  localparam int PAD_W   = MAX_ALIGN_LOG2;
  localparam int SLOT_W  = $clog2(REGION_BYTES);
  localparam int NEED_W  = OFF_W + 1;
  localparam int HDR_W   = OFF_W + PAD_W + OFF_W;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TO_MARK = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_RANGE   = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_BASE     = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_index_t;

  // Block header kept at the header offset of each block.
  typedef struct packed {
    logic [OFF_W-1:0] size;
    logic [PAD_W-1:0] pad;
    logic [OFF_W-1:0] back;
  } hdr_t;

endpackage

[design/asa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module asa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/aligned_stack_allocator.sv]
// Top level of the aligned stack allocator: request decode, header memory and result register.
//
// Usage:
//   Requests arrive on the in_ stream: in_tuser carries the opcode (allocate,
//   release last, release to mark, clear) and in_tdata the size, alignment and
//   mark. Every request yields exactly one result on the out_ stream: out_tuser
//   carries the status and out_tdata the block address, new top and bytes in use.
//   Block headers live in a 1024-entry synchronous RAM indexed by region offset.
//   In the accept cycle the request reads the header RAM (the last
//   header for release last, the mark's header for release to mark) and
//   precomputes the header address; the next cycle applies the update, writes
//   a new header for a successful allocate and loads the result register.
//   The result register loads at the end of the execute cycle, which raises
//   out_tvalid; no request is taken during the execute cycle, so a new
//   request is accepted only once the previous one has executed.
//   A result held by a stalled receiver blocks the next request: in_tready
//   stays low until that result is taken.
//   Reset (rst_n low, synchronous) empties the stack, sets base_address to 0
//   and capacity_bytes to 1024; header RAM contents are left as they are.
//   Configuration writes via cfg_we, cfg_index, cfg_wdata: user keeps them to idle; not checked.
module aligned_stack_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_size[10:0], align_log2[13:11], mark_offset[24:14]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // block_address[31:0], top_mark[42:32], allocated_bytes[53:43]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import asa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } fsm_t;

  fsm_t state_r, state_nxt;

  // Configuration and allocator state.
  logic [ADDR_W-1:0] base_r;
  logic [OFF_W-1:0]  cap_r;
  logic [OFF_W-1:0]  top_r, top_nxt;
  logic [OFF_W-1:0]  last_r, last_nxt;
  logic [OFF_W-1:0]  used_r, used_nxt;

  // Captured request.
  opcode_t           op_r;
  logic [OFF_W-1:0]  size_r;
  logic [ALOG_W-1:0] alog_r;
  logic [OFF_W-1:0]  mark_r;
  logic [ADDR_W-1:0] hdr_addr_r;

  // Result register.
  logic              out_valid_r;
  status_t           out_status_r, status_c;
  logic [ADDR_W-1:0] out_addr_r, addr_c;
  logic [OFF_W-1:0]  out_top_r;
  logic [OFF_W-1:0]  out_used_r;

  // Request field unpacking.
  logic [OFF_W-1:0]  in_size;
  logic [ALOG_W-1:0] in_alog;
  logic [OFF_W-1:0]  in_mark;
  logic              in_acc;

  assign in_size = in_tdata[10:0];
  assign in_alog = in_tdata[13:11];
  assign in_mark = in_tdata[24:14];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Header memory.
  logic              hdr_we;
  logic [SLOT_W-1:0] hdr_raddr;
  hdr_t              hdr_wdata;
  hdr_t              hdr_rd;
  logic [HDR_W-1:0]  hdr_rdata;

  assign hdr_raddr = (opcode_t'(in_tuser) == OP_TO_MARK) ? in_mark[SLOT_W-1:0]
                                                         : last_r[SLOT_W-1:0];
  assign hdr_rd    = hdr_t'(hdr_rdata);

  asa_ram #(
    .WIDTH (HDR_W),
    .DEPTH (REGION_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (top_r[SLOT_W-1:0]),
    .wdata (hdr_wdata),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  // Allocation arithmetic.
  logic [OFF_W-1:0]   cap_eff;
  logic [MAX_ALIGN_LOG2:0] align_full;
  logic [PAD_W-1:0]   pad;
  logic [NEED_W-1:0]  need;
  logic [OFF_W-1:0]   freeb;
  logic [NEED_W:0]    new_end;
  logic               alloc_fail;
  logic [OFF_W-1:0]   back;
  logic [NEED_W:0]    amount;
  logic [OFF_W-1:0]   rel_used;
  logic [OFF_W-1:0]   mark_used;
  logic [OFF_W-1:0]   mark_last;

  assign cap_eff    = (cap_r > OFF_W'(REGION_BYTES)) ? OFF_W'(REGION_BYTES) : cap_r;
  assign align_full = (MAX_ALIGN_LOG2+1)'(((MAX_ALIGN_LOG2+1)'(1) << alog_r)
                      - (MAX_ALIGN_LOG2+1)'(1));
  assign pad        = (PAD_W'(0) - hdr_addr_r[PAD_W-1:0]) & align_full[PAD_W-1:0];
  assign need       = NEED_W'(HEADER_BYTES) + NEED_W'(pad) + NEED_W'(size_r);
  assign freeb      = (cap_eff >= used_r) ? (cap_eff - used_r) : '0;
  assign new_end    = (NEED_W+1)'(top_r) + (NEED_W+1)'(need);
  assign alloc_fail = (size_r == '0) || (need > NEED_W'(freeb))
                      || (new_end > (NEED_W+1)'(cap_eff));
  assign back       = (top_r >= last_r) ? (top_r - last_r) : '0;

  // Release arithmetic.
  assign amount    = (NEED_W+1)'(hdr_rd.size) + (NEED_W+1)'(hdr_rd.pad)
                     + (NEED_W+1)'(HEADER_BYTES);
  assign rel_used  = ((NEED_W+1)'(used_r) >= amount) ? OFF_W'((NEED_W+1)'(used_r) - amount)
                                                      : '0;
  assign mark_used = (used_r >= (top_r - mark_r)) ? (used_r - (top_r - mark_r)) : '0;
  assign mark_last = (mark_r >= hdr_rd.back) ? (mark_r - hdr_rd.back) : '0;

  assign hdr_wdata.size = size_r;
  assign hdr_wdata.pad  = pad;
  assign hdr_wdata.back = back;

  // Idle waits for a request; the execute cycle applies the opcode to the allocator state.
  always_comb begin
    top_nxt   = top_r;
    last_nxt  = last_r;
    used_nxt  = used_r;
    status_c  = STAT_OK;
    addr_c    = '0;
    hdr_we    = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_ALLOC: begin
            if (alloc_fail) begin
              status_c = STAT_NOSPACE;
            end else begin
              hdr_we   = 1'b1;
              addr_c   = hdr_addr_r + ADDR_W'(pad);
              last_nxt = top_r;
              top_nxt  = OFF_W'(new_end);
              used_nxt = OFF_W'(NEED_W'(used_r) + need);
            end
          end
          OP_RELEASE: begin
            if (used_r == '0) begin
              status_c = STAT_EMPTY;
            end else begin
              top_nxt  = last_r;
              last_nxt = (last_r >= hdr_rd.back) ? (last_r - hdr_rd.back) : '0;
              used_nxt = rel_used;
            end
          end
          OP_TO_MARK: begin
            if (used_r == '0) begin
              status_c = STAT_EMPTY;
            end else if (mark_r > top_r) begin
              status_c = STAT_RANGE;
            end else if (mark_r < top_r) begin
              used_nxt = mark_used;
              last_nxt = mark_last;
              top_nxt  = mark_r;
            end
          end
          OP_CLEAR: begin
            top_nxt  = '0;
            last_nxt = '0;
            used_nxt = '0;
          end
          default: begin
            status_c = STAT_OK;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and allocator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      cap_r       <= OFF_W'(REGION_BYTES);
      top_r       <= '0;
      last_r      <= '0;
      used_r      <= '0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      last_r  <= last_nxt;
      used_r  <= used_nxt;
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_BASE:     base_r <= cfg_wdata;
          CFG_CAPACITY: cap_r  <= cfg_wdata[OFF_W-1:0];
          default:      base_r <= base_r;
        endcase
      end
      if (state_r == S_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture; the header address is formed here to shorten the execute path.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r       <= opcode_t'(in_tuser);
      size_r     <= in_size;
      alog_r     <= (in_alog > ALOG_W'(MAX_ALIGN_LOG2)) ? ALOG_W'(MAX_ALIGN_LOG2) : in_alog;
      mark_r     <= in_mark;
      hdr_addr_r <= base_r + ADDR_W'(top_r) + ADDR_W'(HEADER_BYTES);
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      out_status_r <= status_c;
      out_addr_r   <= addr_c;
      out_top_r    <= top_nxt;
      out_used_r   <= used_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_used_r, out_top_r, out_addr_r};

`ifndef SYNTH
  // An accepted request always moves into the execute cycle.
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted request did not enter execute");

  // The result register is free whenever a result is produced.
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !out_valid_r)
    else $error("result register overwritten");

  // Every execute cycle presents a result next.
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid_r)
    else $error("execute cycle gave no result");

  // A failed request never reports an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_addr_r == '0))
    else $error("address reported on failed request");

  // No new request is taken while the execute cycle runs.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !in_tready)
    else $error("request accepted during execute");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the aligned stack allocator: corner cases, stalls, random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import asa_pkg::*;

  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned ERROR_PRINTS = 40;

  // Expected content of one result.
  typedef struct {
    status_t     status;
    logic [31:0] address;
    logic [10:0] top;
    logic [10:0] used;
  } outcome_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [31:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shadow copy of the allocator state and its settings.
  int unsigned region_base     = 0;
  int unsigned region_capacity = 1024;
  int unsigned stack_top       = 0;
  int unsigned last_header     = 0;
  int unsigned bytes_in_use    = 0;
  int unsigned hdr_size [REGION_BYTES];
  int unsigned hdr_pad  [REGION_BYTES];
  int unsigned hdr_back [REGION_BYTES];
  bit          hdr_written [REGION_BYTES];

  outcome_t    pending_outcomes[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_left      = 0;
  int unsigned stuck_cycles   = 0;

  aligned_stack_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned floor_sub(int unsigned a, int unsigned b);
    return (a >= b) ? a - b : 0;
  endfunction

  // Applies one request to the shadow state and returns the result it must produce.
  function automatic outcome_t predict_outcome(opcode_t op, logic [10:0] size_in,
                                               logic [2:0] alog_in, logic [10:0] mark_in);
    outcome_t    r;
    int unsigned cap, alog, align, pad, need, free_bytes, hdr_addr, amount, slot;
    int unsigned size, mark;
    size      = size_in;
    mark      = mark_in;
    r.status  = STAT_OK;
    r.address = '0;
    case (op)
      OP_ALLOC: begin
        cap        = (region_capacity > REGION_BYTES) ? REGION_BYTES : region_capacity;
        alog       = (alog_in > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : alog_in;
        align      = 1 << alog;
        hdr_addr   = region_base + stack_top + HEADER_BYTES;
        pad        = (~hdr_addr + 1) & (align - 1);
        need       = HEADER_BYTES + pad + size;
        free_bytes = floor_sub(cap, bytes_in_use);
        if (size == 0 || need > free_bytes || stack_top + need > cap) begin
          r.status = STAT_NOSPACE;
        end else begin
          slot              = stack_top % REGION_BYTES;
          hdr_size[slot]    = size;
          hdr_pad[slot]     = pad;
          hdr_back[slot]    = floor_sub(stack_top, last_header) & 32'h7FF;
          hdr_written[slot] = 1'b1;
          r.address         = hdr_addr + pad;
          last_header       = stack_top;
          stack_top         = (stack_top + need) & 32'h7FF;
          bytes_in_use      = (bytes_in_use + need) & 32'h7FF;
        end
      end
      OP_RELEASE: begin
        if (bytes_in_use == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          slot         = last_header % REGION_BYTES;
          amount       = hdr_size[slot] + hdr_pad[slot] + HEADER_BYTES;
          stack_top    = last_header;
          last_header  = floor_sub(last_header, hdr_back[slot]);
          bytes_in_use = floor_sub(bytes_in_use, amount);
        end
      end
      OP_TO_MARK: begin
        if (bytes_in_use == 0) begin
          r.status = STAT_EMPTY;
        end else if (mark > stack_top) begin
          r.status = STAT_RANGE;
        end else if (mark < stack_top) begin
          slot         = mark % REGION_BYTES;
          bytes_in_use = floor_sub(bytes_in_use, stack_top - mark);
          last_header  = floor_sub(mark, hdr_back[slot]);
          stack_top    = mark;
        end
      end
      default: begin
        stack_top    = 0;
        last_header  = 0;
        bytes_in_use = 0;
      end
    endcase
    r.top  = stack_top[10:0];
    r.used = bytes_in_use[10:0];
    return r;
  endfunction

  // True when the request would read a header slot that was never written.
  function automatic bit reads_blank_header(opcode_t op, logic [10:0] mark);
    if (bytes_in_use == 0) return 1'b0;
    if (op == OP_RELEASE) return !hdr_written[last_header % REGION_BYTES];
    if (op == OP_TO_MARK && mark < stack_top) return !hdr_written[mark % REGION_BYTES];
    return 1'b0;
  endfunction

  // Offers one request, with an optional idle gap first, and waits for its acceptance.
  task automatic send_request(input opcode_t op, input logic [10:0] size,
                              input logic [2:0] alog, input logic [10:0] mark);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, mark, alog, size};
    do @(posedge clk); while (!in_tready);
    pending_outcomes.push_back(predict_outcome(op, size, alog, mark));
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both configuration registers; only called while the block is idle.
  task automatic apply_settings(input logic [31:0] base, input logic [31:0] capacity);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    region_base = base;
    cfg_index <= CFG_CAPACITY;
    cfg_wdata <= capacity;
    @(posedge clk);
    region_capacity = capacity & 32'h7FF;
    cfg_we <= 1'b0;
  endtask

  // Releases on an empty stack, clear, and a zero-size allocation.
  task automatic test_empty_requests();
    apply_settings(32'hFFFF_FFF0, 1024);
    send_request(OP_RELEASE, 11'd0, 3'd0, 11'd0);
    send_request(OP_TO_MARK, 11'd0, 3'd0, 11'd0);
    send_request(OP_CLEAR, 11'd0, 3'd0, 11'd0);
    send_request(OP_ALLOC, 11'd0, 3'd0, 11'd0);
    wait_drained();
  endtask

  // Alignment padding, saturated alignment, address wrap, marks and exact fill.
  task automatic test_alignment_and_wrap();
    send_request(OP_ALLOC, 11'd1, 3'd0, 11'd0);
    send_request(OP_ALLOC, 11'd1024, 3'd0, 11'd0);
    send_request(OP_ALLOC, 11'd5, 3'd6, 11'd0);
    send_request(OP_ALLOC, 11'd3, 3'd7, 11'd0);
    send_request(OP_TO_MARK, 11'd0, 3'd0, 11'd1024);
    send_request(OP_TO_MARK, 11'd0, 3'd0, stack_top[10:0]);
    send_request(OP_TO_MARK, 11'd0, 3'd0, last_header[10:0]);
    send_request(OP_RELEASE, 11'd0, 3'd0, 11'd0);
    send_request(OP_RELEASE, 11'd0, 3'd0, 11'd0);
    send_request(OP_RELEASE, 11'd0, 3'd0, 11'd0);
    // Header at the region start plus 1012 bytes fills the region exactly.
    send_request(OP_ALLOC, 11'd1012, 3'd0, 11'd0);
    send_request(OP_ALLOC, 11'd1, 3'd0, 11'd0);
    send_request(OP_TO_MARK, 11'd0, 3'd0, stack_top[10:0]);
    send_request(OP_RELEASE, 11'd0, 3'd0, 11'd0);
    wait_drained();
  endtask

  // Capacity above the region size, a capacity of one byte, and capacity below usage.
  task automatic test_capacity_limits();
    apply_settings(32'h0000_0007, 2047);
    send_request(OP_ALLOC, 11'd1012, 3'd0, 11'd0);
    send_request(OP_CLEAR, 11'd0, 3'd0, 11'd0);
    send_request(OP_ALLOC, 11'd100, 3'd2, 11'd0);
    wait_drained();
    apply_settings(32'h0000_0007, 1);
    send_request(OP_ALLOC, 11'd1, 3'd0, 11'd0);
    send_request(OP_RELEASE, 11'd0, 3'd0, 11'd0);
    send_request(OP_ALLOC, 11'd1, 3'd0, 11'd0);
    wait_drained();
  endtask

  // Mostly well-formed allocate and release sequences, with some noise.
  task automatic run_random_traffic(input int unsigned n_items);
    opcode_t     op;
    logic [10:0] size, mark;
    logic [2:0]  alog;
    int unsigned pick, sel, hops, node;
    int unsigned marks[$];
    repeat (n_items) begin
      pick = $urandom_range(99);
      sel  = $urandom_range(19);
      if (sel == 0) size = 11'd0;
      else if (sel == 1) size = 11'($urandom_range(1024));
      else size = 11'($urandom_range(1, 64));
      alog = 3'($urandom_range(7));
      mark = 11'($urandom_range(1024));
      if (pick < 50) begin
        op = OP_ALLOC;
      end else if (pick < 75) begin
        op = OP_RELEASE;
      end else if (pick < 94) begin
        op = OP_TO_MARK;
        // Walk the header chain to collect marks at live block boundaries.
        marks = {};
        marks.push_back(stack_top);
        node = last_header;
        for (hops = 0; hops < 64; hops++) begin
          if (bytes_in_use == 0 || node >= stack_top || !hdr_written[node % REGION_BYTES])
            break;
          marks.push_back(node);
          if (node == 0 || hdr_back[node % REGION_BYTES] == 0) break;
          node = floor_sub(node, hdr_back[node % REGION_BYTES]);
        end
        if ($urandom_range(7) != 0) mark = 11'(marks[$urandom_range(marks.size() - 1)]);
      end else if (pick < 97) begin
        op = OP_CLEAR;
      end else begin
        op = opcode_t'($urandom_range(3));
      end
      if (reads_blank_header(op, mark)) op = OP_ALLOC;
      send_request(op, size, alog, mark);
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    apply_settings(32'h0000_1000, 1024);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = HOLD_CYCLES;
    run_random_traffic(30);
    wait_drained();
  endtask

  // Result receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < ERROR_PRINTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        if (mismatch_count < ERROR_PRINTS)
          $display("%0t: unexpected result, expected none, actual status %0d data %0h",
                   $time, out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("block_address", want.address, out_tdata[31:0]);
        check_field("top_mark", want.top, out_tdata[42:32]);
        check_field("allocated_bytes", want.used, out_tdata[53:43]);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_requests();
    test_alignment_and_wrap();
    test_capacity_limits();
    test_backpressure();

    apply_settings($urandom, 1024);
    send_idle_pct = 32;
    recv_idle_pct = 75;
    run_random_traffic(230);
    wait_drained();

    apply_settings(32'hFFFF_FFFF, $urandom_range(200, 1024));
    send_idle_pct = 75;
    recv_idle_pct = 32;
    run_random_traffic(230);
    wait_drained();

    apply_settings(32'h0000_0000, 1024);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(230);
    wait_drained();

    if (mismatch_count == 0 && pending_outcomes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
